// ----- src/cbmsi_pkg.sv -----
// ----------------------------------------------------------------------------
// cbmsi_pkg
// Shared types and constants of the cartridge bank mapper with scanline IRQ.
// ----------------------------------------------------------------------------
package cbmsi_pkg;

  // Work RAM size in bytes; a power of two between 1 KB and 8 KB
  localparam int RAM_BYTES = 8192;
  localparam int RAM_AW    = $clog2(RAM_BYTES);

  // Event kinds carried in the input word's tuser
  typedef enum logic [2:0] {
    MODE_CPU_READ  = 3'd0,
    MODE_CPU_WRITE = 3'd1,
    MODE_PPU_READ  = 3'd2,
    MODE_SCANLINE  = 3'd3,
    MODE_IRQ_ACK   = 3'd4
  } mode_t;

  // Result kinds carried in the output word's tuser
  typedef enum logic [1:0] {
    KIND_UNMAPPED = 2'd0,
    KIND_ROM      = 2'd1,
    KIND_RAM      = 2'd2
  } kind_t;

  // Nametable mirroring codes
  typedef enum logic [1:0] {
    MIRROR_HARDWARE   = 2'd0,
    MIRROR_VERTICAL   = 2'd1,
    MIRROR_HORIZONTAL = 2'd2
  } mirror_t;

  // Configuration register indexes
  localparam logic CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic CFG_PRG_RAM_ENABLE = 1'b1;

  // Register write addresses
  localparam logic [15:0] REG_PRG_BANK0  = 16'h8000;
  localparam logic [15:0] REG_PRG_BANK1  = 16'h8001;
  localparam logic [15:0] REG_CHR_WIDE0  = 16'h8002;
  localparam logic [15:0] REG_CHR_WIDE1  = 16'h8003;
  localparam logic [15:0] REG_CHR_NAR0   = 16'hA000;
  localparam logic [15:0] REG_CHR_NAR1   = 16'hA001;
  localparam logic [15:0] REG_CHR_NAR2   = 16'hA002;
  localparam logic [15:0] REG_CHR_NAR3   = 16'hA003;
  localparam logic [15:0] REG_IRQ_LATCH  = 16'hC000;
  localparam logic [15:0] REG_IRQ_CLEAR  = 16'hC001;
  localparam logic [15:0] REG_IRQ_ENABLE = 16'hC002;
  localparam logic [15:0] REG_IRQ_SET    = 16'hC003;
  localparam logic [15:0] REG_MIRROR     = 16'hE000;

  // Bank count loaded at reset, in 16 KB units
  localparam logic [5:0] PRG_COUNT_RESET = 6'd8;

endpackage

// ----- src/cbmsi_ram.sv -----
// ----------------------------------------------------------------------------
// cbmsi_ram
// Generic single-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cbmsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on we, register read data on re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/cartridge_bank_mapper_scanline_irq.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_scanline_irq
// Bank mapper with scanline interrupt counter and optional work RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one bus event per word; tuser is the event kind, tdata carries the
//           address and the CPU write byte.
//   out_* : one result word per event; tuser is the result kind, tdata carries
//           the mapped ROM address, the RAM read byte, the IRQ line and the
//           mirroring mode as they stand after the event.
//   cfg_* : write port for the bank count and the RAM enable; write only while
//           no event is in flight.
// out_tvalid rises in the cycle after accept; one word is accepted every
// cycle while out_tready allows. Bank registers and the IRQ counter update at
// accept; the work RAM is a synchronous memory read at accept, its data lined
// up with the output register. The output register holds while out_tready is
// low and in_tready follows it, so a stalled receiver stops the input.
// Reset clears all banks, the IRQ state and mirroring, loads the last two
// program banks for a count of eight and disables the work RAM. RAM contents
// are undefined until written.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_scanline_irq (
  input  logic        clk,
  input  logic        rst_n,
  // tuser: mode[2:0]
  input  logic [2:0]  in_tuser,
  // tdata: address[15:0], write_data[23:16]
  input  logic [23:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tuser: access_kind[1:0]
  output logic [1:0]  out_tuser,
  // tdata: mapped_address[18:0], read_data[26:19], irq_active[27],
  //        mirror_mode[29:28], zero[31:30]
  output logic [31:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_wdata
);

  // Bank and IRQ state
  logic [5:0] prg_bank_r [4];
  logic [5:0] prg_bank_nxt [4];
  logic [7:0] chr_wide_r [2];
  logic [7:0] chr_wide_nxt [2];
  logic [7:0] chr_nar_r [4];
  logic [7:0] chr_nar_nxt [4];
  logic [7:0] irq_reload_r, irq_reload_nxt;
  logic [7:0] irq_count_r, irq_count_nxt;
  logic       irq_armed_r, irq_armed_nxt;
  logic       irq_pending_r, irq_pending_nxt;
  cbmsi_pkg::mirror_t mirror_r, mirror_nxt;
  logic       ram_en_r;

  // Output register
  logic                out_valid_r;
  cbmsi_pkg::kind_t    out_kind_r, out_kind_nxt;
  logic [18:0]         out_mapped_r, out_mapped_nxt;
  logic                out_ram_rd_r, out_ram_rd_nxt;
  logic                out_irq_r;
  cbmsi_pkg::mirror_t  out_mirror_r;

  // Input word fields
  cbmsi_pkg::mode_t mode;
  logic [15:0]      address;
  logic [7:0]       write_data;
  logic             accept;
  logic             ram_hit;
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata;
  logic [5:0]       twice_count;

  assign mode       = cbmsi_pkg::mode_t'(in_tuser);
  assign address    = in_tdata[15:0];
  assign write_data = in_tdata[23:16];
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign ram_hit    = ram_en_r && (address[15:13] == 3'b011);
  assign twice_count = {cfg_wdata[4:0], 1'b0};

  // Work RAM access at accept
  assign ram_we = accept && ram_hit && (mode == cbmsi_pkg::MODE_CPU_WRITE);
  assign ram_re = accept && ram_hit && (mode == cbmsi_pkg::MODE_CPU_READ);

  cbmsi_ram #(
    .WIDTH (8),
    .DEPTH (cbmsi_pkg::RAM_BYTES)
  ) u_work_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (address[cbmsi_pkg::RAM_AW-1:0]),
    .wdata (write_data),
    .rdata (ram_rdata)
  );

  // Decode the event, update state and form the result
  always_comb begin
    prg_bank_nxt    = prg_bank_r;
    chr_wide_nxt    = chr_wide_r;
    chr_nar_nxt     = chr_nar_r;
    irq_reload_nxt  = irq_reload_r;
    irq_count_nxt   = irq_count_r;
    irq_armed_nxt   = irq_armed_r;
    irq_pending_nxt = irq_pending_r;
    mirror_nxt      = mirror_r;
    out_kind_nxt    = cbmsi_pkg::KIND_UNMAPPED;
    out_mapped_nxt  = '0;
    out_ram_rd_nxt  = 1'b0;
    case (mode)
      cbmsi_pkg::MODE_CPU_READ: begin
        if (ram_hit) begin
          out_kind_nxt   = cbmsi_pkg::KIND_RAM;
          out_ram_rd_nxt = 1'b1;
        end else if (address[15]) begin
          out_kind_nxt   = cbmsi_pkg::KIND_ROM;
          out_mapped_nxt = {prg_bank_r[address[14:13]], address[12:0]};
        end
      end
      cbmsi_pkg::MODE_CPU_WRITE: begin
        if (ram_hit) begin
          out_kind_nxt = cbmsi_pkg::KIND_RAM;
        end else begin
          case (address)
            cbmsi_pkg::REG_PRG_BANK0:  prg_bank_nxt[0] = write_data[5:0];
            cbmsi_pkg::REG_PRG_BANK1:  prg_bank_nxt[1] = write_data[5:0];
            cbmsi_pkg::REG_CHR_WIDE0:  chr_wide_nxt[0] = write_data;
            cbmsi_pkg::REG_CHR_WIDE1:  chr_wide_nxt[1] = write_data;
            cbmsi_pkg::REG_CHR_NAR0:   chr_nar_nxt[0] = {write_data[7:1], 1'b0};
            cbmsi_pkg::REG_CHR_NAR1:   chr_nar_nxt[1] = {write_data[7:1], 1'b0};
            cbmsi_pkg::REG_CHR_NAR2:   chr_nar_nxt[2] = {write_data[7:1], 1'b0};
            cbmsi_pkg::REG_CHR_NAR3:   chr_nar_nxt[3] = {write_data[7:1], 1'b0};
            cbmsi_pkg::REG_IRQ_LATCH:  irq_reload_nxt = ~write_data;
            cbmsi_pkg::REG_IRQ_CLEAR:  irq_count_nxt = '0;
            cbmsi_pkg::REG_IRQ_ENABLE: irq_armed_nxt = 1'b1;
            cbmsi_pkg::REG_IRQ_SET:    irq_pending_nxt = 1'b1;
            cbmsi_pkg::REG_MIRROR: begin
              mirror_nxt = write_data[6] ? cbmsi_pkg::MIRROR_HORIZONTAL
                                         : cbmsi_pkg::MIRROR_VERTICAL;
            end
            default: ;
          endcase
        end
      end
      cbmsi_pkg::MODE_PPU_READ: begin
        if (address[15:12] == 4'h0) begin
          out_kind_nxt   = cbmsi_pkg::KIND_ROM;
          out_mapped_nxt = {chr_wide_r[address[11]], address[10:0]};
        end else if (address[15:12] == 4'h1) begin
          out_kind_nxt   = cbmsi_pkg::KIND_ROM;
          out_mapped_nxt = {1'b0, chr_nar_r[address[11:10]], address[9:0]};
        end
      end
      cbmsi_pkg::MODE_SCANLINE: begin
        // Reload at zero, else count down and raise the line on reaching zero if armed
        if (irq_count_r == 8'd0) begin
          irq_count_nxt = irq_reload_r;
        end else begin
          irq_count_nxt = irq_count_r - 8'd1;
          if (irq_count_r == 8'd1 && irq_armed_r) begin
            irq_pending_nxt = 1'b1;
          end
        end
      end
      cbmsi_pkg::MODE_IRQ_ACK: irq_pending_nxt = 1'b0;
      default: ;
    endcase
  end

  // Take configuration writes, which win over accept; else commit state at accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_r[0] <= '0;
      prg_bank_r[1] <= '0;
      prg_bank_r[2] <= {cbmsi_pkg::PRG_COUNT_RESET[4:0], 1'b0} - 6'd2;
      prg_bank_r[3] <= {cbmsi_pkg::PRG_COUNT_RESET[4:0], 1'b0} - 6'd1;
      chr_wide_r    <= '{default: '0};
      chr_nar_r     <= '{default: '0};
      irq_reload_r  <= '0;
      irq_count_r   <= '0;
      irq_armed_r   <= 1'b0;
      irq_pending_r <= 1'b0;
      mirror_r      <= cbmsi_pkg::MIRROR_HARDWARE;
      ram_en_r      <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == cbmsi_pkg::CFG_PRG_BANK_COUNT) begin
        prg_bank_r[2] <= twice_count - 6'd2;
        prg_bank_r[3] <= twice_count - 6'd1;
      end else begin
        ram_en_r <= cfg_wdata[0];
      end
    end else if (accept) begin
      prg_bank_r    <= prg_bank_nxt;
      chr_wide_r    <= chr_wide_nxt;
      chr_nar_r     <= chr_nar_nxt;
      irq_reload_r  <= irq_reload_nxt;
      irq_count_r   <= irq_count_nxt;
      irq_armed_r   <= irq_armed_nxt;
      irq_pending_r <= irq_pending_nxt;
      mirror_r      <= mirror_nxt;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind_r   <= out_kind_nxt;
      out_mapped_r <= out_mapped_nxt;
      out_ram_rd_r <= out_ram_rd_nxt;
      out_irq_r    <= irq_pending_nxt;
      out_mirror_r <= mirror_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {2'b00, out_mirror_r, out_irq_r,
                       (out_ram_rd_r ? ram_rdata : 8'd0), out_mapped_r};

endmodule
